>>> hdl/lbg_pkg.sv
// shared types, constants and helper functions for the led bar graph painter
package lbg_pkg;

    localparam int unsigned RpmLimit  = 8000;
    localparam int unsigned RpmBand   = 1400;
    localparam int unsigned KmhLimit  = 167;
    localparam int unsigned KmhBand   = 24;
    // reciprocal of 56 scaled by 2^16, exact for differences below 1400
    localparam int unsigned RpmRecip  = 1171;

    localparam logic [5:0] BaseLeft   = 6'd56;
    localparam logic [5:0] BaseRight  = 6'd61;

    localparam logic REQ_RPM = 1'b0;
    localparam logic REQ_KMH = 1'b1;

    typedef struct packed {
        logic        bar_slot;
        logic [23:0] color;
        logic [4:0]  height;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [23:0] band_color(input logic [2:0] band);
        logic [23:0] c;
        unique case (band)
            3'd0:    c = 24'h4444dd;
            3'd1:    c = 24'h00eeff;
            3'd2:    c = 24'h69d025;
            3'd3:    c = 24'hccbb33;
            3'd4:    c = 24'hff9900;
            3'd5:    c = 24'hff0000;
            3'd6:    c = 24'hff9999;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // height / 3 via multiply by 11 and shift, exact for heights below 32
    function automatic logic [3:0] div3(input logic [4:0] h);
        logic [8:0] p;
        p = 9'(h) * 9'd11;
        return p[8:5];
    endfunction

endpackage

>>> hdl/led_bar_graph_painter_top.sv
// led bar graph painter: one gauge reading in, 24 pixel writes out
// path: front stages s1-s3, queue, sequencer, output register; then one write per cycle
// throughput: bounded by the pixel sequencer, which draws one bar at a time at one write a cycle
// a queue between front end and sequencer lets readings be taken while a bar is drawn
// reset: rst_n clears all pipeline valids, the queue and the sequencer; no writes follow
// results carry no back-pressure and must be taken on the cycle result_valid is high
module led_bar_graph_painter_top
    import lbg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic        bar_slot,
    input  logic [15:0] metric_value,
    output logic        result_valid,
    output logic [5:0]  led_index,
    output logic [23:0] led_color,
    output logic        frame_last
);

    q_stat_t qstat;
    logic    push, pop;
    job_t    push_job, pop_job;

    lbg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .bar_slot     (bar_slot),
        .metric_value (metric_value),
        .qstat        (qstat),
        .push         (push),
        .push_job     (push_job)
    );

    lbg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    lbg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_job      (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .led_index    (led_index),
        .led_color    (led_color),
        .frame_last   (frame_last)
    );

    // commit mark only on a real transfer
    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        frame_last |-> result_valid)
        else $error("frame_last without result_valid");

    // the 24 writes of one bar come out without gaps
    a_bar_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !frame_last |=> result_valid)
        else $error("gap inside a bar");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    // the sequencer never takes a job from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop on empty queue");

endmodule

>>> hdl/lbg_front.sv
// front end: clamps the reading, finds colour band and bar height, feeds the queue
module lbg_front
    import lbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic        bar_slot,
    input  logic [15:0] metric_value,
    input  q_stat_t     qstat,
    output logic        push,
    output job_t        push_job
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_ready, s2_ready, s3_ready;

    logic        s1_type_reg, s1_slot_reg;
    logic [12:0] s1_val_reg;
    logic [2:0]  s1_band_reg;

    logic        s2_type_reg, s2_slot_reg;
    logic [10:0] s2_diff_reg;
    logic [2:0]  s2_band_reg;

    job_t        s3_job_reg;

    logic [12:0] s1_val_next;
    logic [2:0]  s1_band_next;
    logic [12:0] s2_offset;
    logic [12:0] s2_diff_full;
    logic [21:0] s3_prod;
    logic [4:0]  s3_height_next;

    assign s3_ready = !s3_valid_reg || !qstat.full;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign busy     = !s1_ready;
    assign push     = s3_valid_reg && !qstat.full;
    assign push_job = s3_job_reg;

    // clamp and band select
    always_comb
    begin
        if (req_type == REQ_RPM)
        begin
            s1_val_next = (metric_value > 16'(RpmLimit)) ? 13'(RpmLimit)
                                                         : metric_value[12:0];
            s1_band_next = 3'd0;
            for (int b = 1; b <= 5; b++)
            begin
                if (s1_val_next >= 13'(b * RpmBand))
                    s1_band_next = 3'(b);
            end
        end
        else
        begin
            s1_val_next = (metric_value > 16'(KmhLimit)) ? 13'(KmhLimit)
                                                         : metric_value[12:0];
            s1_band_next = 3'd0;
            for (int b = 1; b <= 6; b++)
            begin
                if (s1_val_next >= 13'(b * KmhBand))
                    s1_band_next = 3'(b);
            end
        end
    end

    // offset within the band
    always_comb
    begin
        if (s1_type_reg == REQ_RPM)
            s2_offset = 13'(s1_band_reg) * 13'(RpmBand);
        else
            s2_offset = 13'(s1_band_reg) * 13'(KmhBand);
        s2_diff_full = s1_val_reg - s2_offset;
    end

    // height: offset / 56 for rpm, offset itself for km/h
    always_comb
    begin
        s3_prod = 22'(s2_diff_reg) * 22'(RpmRecip);
        if (s2_type_reg == REQ_RPM)
            s3_height_next = s3_prod[20:16];
        else
            s3_height_next = s2_diff_reg[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= start;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && start)
        begin
            s1_type_reg <= req_type;
            s1_slot_reg <= bar_slot;
            s1_val_reg  <= s1_val_next;
            s1_band_reg <= s1_band_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_type_reg <= s1_type_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_diff_reg <= s2_diff_full[10:0];
            s2_band_reg <= s1_band_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_job_reg.bar_slot <= s2_slot_reg;
            s3_job_reg.color    <= band_color(s2_band_reg);
            s3_job_reg.height   <= s3_height_next;
        end
    end

endmodule

>>> hdl/lbg_queue.sv
// short job queue between the front end and the pixel sequencer
module lbg_queue
    import lbg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_job     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> hdl/lbg_back.sv
// pixel sequencer: walks the 24 pixels of a bar and drives one write per cycle
module lbg_back
    import lbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     qstat,
    input  job_t        pop_job,
    output logic        pop,
    output logic        result_valid,
    output logic [5:0]  led_index,
    output logic [23:0] led_color,
    output logic        frame_last
);

    logic        active_reg;
    logic [2:0]  slot_reg;
    logic [1:0]  col_reg;
    logic        bar_reg;
    logic [23:0] color_reg;
    logic [3:0]  h3_reg;
    logic [1:0]  rem_reg;

    logic        valid_reg, last_reg;
    logic [5:0]  index_reg;
    logic [23:0] pix_color_reg;

    logic        last_step;
    logic        lit;
    logic [2:0]  row;
    logic [23:0] pix_color;
    logic [5:0]  base;
    logic [5:0]  index_next;
    logic [3:0]  load_h3;
    logic [4:0]  load_h3x3;

    assign last_step = (slot_reg == 3'd7) && (col_reg == 2'd2);
    assign pop       = (!active_reg || last_step) && !qstat.empty;
    assign load_h3   = div3(pop_job.height);
    assign load_h3x3 = 5'(load_h3) + 5'({load_h3, 1'b0});

    // row order: lit rows up, cleared rows down, level row last (when not every row is lit)
    always_comb
    begin
        lit = ({1'b0, slot_reg} < h3_reg);
        if (lit)
        begin
            row       = slot_reg;
            pix_color = color_reg;
        end
        else if (slot_reg == 3'd7)
        begin
            row = h3_reg[2:0];
            unique case (col_reg)
                2'd1:    pix_color = (rem_reg == 2'd2) ? color_reg : 24'h0;
                2'd2:    pix_color = (rem_reg != 2'd0) ? color_reg : 24'h0;
                default: pix_color = 24'h0;
            endcase
        end
        else
        begin
            row       = 3'(4'd7 + h3_reg - {1'b0, slot_reg});
            pix_color = 24'h0;
        end
        base       = bar_reg ? BaseRight : BaseLeft;
        index_next = base + 6'(col_reg) - {row, 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            slot_reg   <= '0;
            col_reg    <= '0;
        end
        else
        begin
            valid_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
                slot_reg   <= '0;
                col_reg    <= '0;
            end
            else if (active_reg)
            begin
                if (last_step)
                    active_reg <= 1'b0;
                if (col_reg == 2'd2)
                begin
                    col_reg  <= '0;
                    slot_reg <= slot_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bar_reg   <= pop_job.bar_slot;
            color_reg <= pop_job.color;
            h3_reg    <= load_h3;
            rem_reg   <= 2'(pop_job.height - load_h3x3);
        end
        index_reg     <= index_next;
        pix_color_reg <= pix_color;
        last_reg      <= last_step;
    end

    assign result_valid = valid_reg;
    assign led_index    = index_reg;
    assign led_color    = pix_color_reg;
    assign frame_last   = valid_reg && last_reg;

endmodule
